[hw/rtl/rodr_pkg.sv]
// ----------------------------------------------------------------------------
// Rotation vector to rotation matrix: shared package
// Payload types, fixed-point constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package rodr_pkg;

  // One input transaction: rotation vector components, signed Q3.28.
  typedef struct packed {
    logic signed [31:0] rot_x;
    logic signed [31:0] rot_y;
    logic signed [31:0] rot_z;
  } rodr_in_t;

  // One output transaction: the matrix in row-major order.
  typedef struct packed {
    logic signed [31:0] m00;
    logic signed [31:0] m01;
    logic signed [31:0] m02;
    logic signed [31:0] m10;
    logic signed [31:0] m11;
    logic signed [31:0] m12;
    logic signed [31:0] m20;
    logic signed [31:0] m21;
    logic signed [31:0] m22;
  } rodr_out_t;

  // Values that ride along the sine/cosine pipeline.
  typedef struct packed {
    logic               zero;  // zero-length vector, result is identity
    logic               neg;   // angle was folded, cosine must be negated
    logic signed [31:0] ux;    // unit axis, Q30
    logic signed [31:0] uy;
    logic signed [31:0] uz;
  } rodr_side_t;

  // Fixed-point constants, Q30 unless stated otherwise.
  localparam logic signed [33:0] OneQ30       = 34'sd1073741824;
  localparam logic        [32:0] TwoPiQ28     = 33'd1686629713;
  localparam logic signed [34:0] PiQ30        = 35'sd3373259426;
  localparam logic signed [34:0] TwoPiQ30     = 35'sd6746518852;
  localparam logic signed [34:0] HalfPiQ30    = 35'sd1686629713;
  localparam logic signed [33:0] CordicGainInv = 34'sd652032874;

  // atan(2^-i) in Q30 for CORDIC stage i.
  function automatic logic signed [33:0] atan_q30(input int unsigned i);
    logic signed [33:0] res;
    case (i)
      0:  res = 34'sd843314856;
      1:  res = 34'sd497837829;
      2:  res = 34'sd263043836;
      3:  res = 34'sd133525158;
      4:  res = 34'sd67021686;
      5:  res = 34'sd33543515;
      6:  res = 34'sd16775850;
      7:  res = 34'sd8388437;
      8:  res = 34'sd4194282;
      9:  res = 34'sd2097149;
      10: res = 34'sd1048575;
      default: begin
        if (i <= 30) begin
          res = 34'sd1 <<< (30 - i);
        end else begin
          res = '0;
        end
      end
    endcase
    return res;
  endfunction

endpackage

[hw/rtl/rodr_norm.sv]
// ----------------------------------------------------------------------------
// Rotation vector norm, unit axis and reduced angle
// Squares and sums the components, takes the integer square root one bit per
// stage, reduces the norm modulo two pi and folds it to [-pi/2, pi/2], then
// divides each component by the norm one quotient bit per stage.
// ----------------------------------------------------------------------------
module rodr_norm (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  rodr_pkg::rodr_in_t  data_i,
  output logic                valid_o,
  output logic signed [33:0]  angle_o,
  output rodr_pkg::rodr_side_t side_o
);

  localparam int unsigned SqrtSteps = 32;
  localparam int unsigned DivSteps  = 31;

  // Squares of the components.
  logic               sq_vld_q;
  logic        [62:0] sq_x_q, sq_y_q, sq_z_q;
  rodr_pkg::rodr_in_t sq_vec_q;
  logic signed [63:0] px_w, py_w, pz_w;

  assign px_w = data_i.rot_x * data_i.rot_x;
  assign py_w = data_i.rot_y * data_i.rot_y;
  assign pz_w = data_i.rot_z * data_i.rot_z;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_vld_q <= 1'b0;
    end else if (en_i) begin
      sq_vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_x_q   <= px_w[62:0];
      sq_y_q   <= py_w[62:0];
      sq_z_q   <= pz_w[62:0];
      sq_vec_q <= data_i;
    end
  end

  // Sum of squares.
  logic               sum_vld_q;
  logic        [63:0] sum_q;
  rodr_pkg::rodr_in_t sum_vec_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_vld_q <= 1'b0;
    end else if (en_i) begin
      sum_vld_q <= sq_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q     <= {1'b0, sq_x_q} + {1'b0, sq_y_q} + {1'b0, sq_z_q};
      sum_vec_q <= sq_vec_q;
    end
  end

  // Integer square root, one root bit per stage.
  logic               rt_vld  [0:SqrtSteps];
  logic        [35:0] rt_rem  [0:SqrtSteps];
  logic        [31:0] rt_root [0:SqrtSteps];
  logic        [63:0] rt_rad  [0:SqrtSteps];
  rodr_pkg::rodr_in_t rt_vec  [0:SqrtSteps];

  assign rt_vld[0]  = sum_vld_q;
  assign rt_rem[0]  = '0;
  assign rt_root[0] = '0;
  assign rt_rad[0]  = sum_q;
  assign rt_vec[0]  = sum_vec_q;

  for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
    logic [35:0] rem_sh_w, trial_w;
    logic        take_w;

    assign rem_sh_w = {rt_rem[k][33:0], rt_rad[k][63:62]};
    assign trial_w  = {2'b00, rt_root[k], 2'b01};
    assign take_w   = (rem_sh_w >= trial_w);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rt_vld[k+1] <= 1'b0;
      end else if (en_i) begin
        rt_vld[k+1] <= rt_vld[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rt_rem[k+1]  <= take_w ? (rem_sh_w - trial_w) : rem_sh_w;
        rt_root[k+1] <= {rt_root[k][30:0], take_w};
        rt_rad[k+1]  <= {rt_rad[k][61:0], 2'b00};
        rt_vec[k+1]  <= rt_vec[k];
      end
    end
  end

  // Norm modulo two pi; the quotient is at most two.
  logic               md_vld_q;
  logic        [30:0] md_r_q;
  logic        [31:0] md_n_q;
  rodr_pkg::rodr_in_t md_vec_q;
  logic        [32:0] md_a_w, md_b_w;

  assign md_a_w = ({1'b0, rt_root[SqrtSteps]} >= rodr_pkg::TwoPiQ28)
                ? ({1'b0, rt_root[SqrtSteps]} - rodr_pkg::TwoPiQ28)
                : {1'b0, rt_root[SqrtSteps]};
  assign md_b_w = (md_a_w >= rodr_pkg::TwoPiQ28) ? (md_a_w - rodr_pkg::TwoPiQ28) : md_a_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      md_vld_q <= 1'b0;
    end else if (en_i) begin
      md_vld_q <= rt_vld[SqrtSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      md_r_q   <= md_b_w[30:0];
      md_n_q   <= rt_root[SqrtSteps];
      md_vec_q <= rt_vec[SqrtSteps];
    end
  end

  // Fold the angle to (-pi, pi] and then to [-pi/2, pi/2].
  logic               fd_vld_q;
  logic signed [33:0] fd_ang_q;
  logic               fd_neg_q;
  logic        [31:0] fd_n_q;
  rodr_pkg::rodr_in_t fd_vec_q;
  logic signed [34:0] fa_w, fb_w, fc_w;
  logic               fneg_w;

  always_comb begin
    fa_w   = $signed({2'b00, md_r_q, 2'b00});
    fb_w   = (fa_w > rodr_pkg::PiQ30) ? (fa_w - rodr_pkg::TwoPiQ30) : fa_w;
    fc_w   = fb_w;
    fneg_w = 1'b0;
    if (fb_w > rodr_pkg::HalfPiQ30) begin
      fc_w   = rodr_pkg::PiQ30 - fb_w;
      fneg_w = 1'b1;
    end else if (fb_w < -rodr_pkg::HalfPiQ30) begin
      fc_w   = -rodr_pkg::PiQ30 - fb_w;
      fneg_w = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fd_vld_q <= 1'b0;
    end else if (en_i) begin
      fd_vld_q <= md_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fd_ang_q <= fc_w[33:0];
      fd_neg_q <= fneg_w;
      fd_n_q   <= md_n_q;
      fd_vec_q <= md_vec_q;
    end
  end

  // Component magnitudes entering the divider.
  logic [31:0] mag_w [0:2];
  logic [2:0]  sgn_w;

  assign sgn_w    = {fd_vec_q.rot_z[31], fd_vec_q.rot_y[31], fd_vec_q.rot_x[31]};
  assign mag_w[0] = sgn_w[0] ? (~fd_vec_q.rot_x + 32'd1) : fd_vec_q.rot_x;
  assign mag_w[1] = sgn_w[1] ? (~fd_vec_q.rot_y + 32'd1) : fd_vec_q.rot_y;
  assign mag_w[2] = sgn_w[2] ? (~fd_vec_q.rot_z + 32'd1) : fd_vec_q.rot_z;

  // Restoring division of (magnitude << 30) by the norm, one bit per stage.
  logic               dv_vld [0:DivSteps];
  logic signed [33:0] dv_ang [0:DivSteps];
  logic               dv_neg [0:DivSteps];
  logic        [31:0] dv_n   [0:DivSteps];
  logic        [2:0]  dv_sgn [0:DivSteps];
  logic        [31:0] dv_rem [0:DivSteps][0:2];
  logic        [30:0] dv_lo  [0:DivSteps][0:2];
  logic        [30:0] dv_quo [0:DivSteps][0:2];

  assign dv_vld[0] = fd_vld_q;
  assign dv_ang[0] = fd_ang_q;
  assign dv_neg[0] = fd_neg_q;
  assign dv_n[0]   = fd_n_q;
  assign dv_sgn[0] = sgn_w;

  for (genvar l = 0; l < 3; l++) begin : g_lane_in
    assign dv_rem[0][l] = {1'b0, mag_w[l][31:1]};
    assign dv_lo[0][l]  = {mag_w[l][0], 30'd0};
    assign dv_quo[0][l] = '0;
  end

  for (genvar j = 0; j < DivSteps; j++) begin : g_div
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld[j+1] <= 1'b0;
      end else if (en_i) begin
        dv_vld[j+1] <= dv_vld[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dv_ang[j+1] <= dv_ang[j];
        dv_neg[j+1] <= dv_neg[j];
        dv_n[j+1]   <= dv_n[j];
        dv_sgn[j+1] <= dv_sgn[j];
      end
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [32:0] rs_w;
      logic        ge_w;

      assign rs_w = {dv_rem[j][l], dv_lo[j][l][30]};
      assign ge_w = (rs_w >= {1'b0, dv_n[j]});

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          dv_rem[j+1][l] <= ge_w ? 32'(rs_w - {1'b0, dv_n[j]}) : rs_w[31:0];
          dv_lo[j+1][l]  <= {dv_lo[j][l][29:0], 1'b0};
          dv_quo[j+1][l] <= {dv_quo[j][l][29:0], ge_w};
        end
      end
    end
  end

  // Apply the signs and hand off to the sine/cosine pipeline.
  logic                 out_vld_q;
  logic signed [33:0]   out_ang_q;
  rodr_pkg::rodr_side_t out_side_q;
  logic signed [31:0]   u_w [0:2];

  for (genvar l = 0; l < 3; l++) begin : g_sign
    assign u_w[l] = dv_sgn[DivSteps][l] ? -$signed({1'b0, dv_quo[DivSteps][l]})
                                        : $signed({1'b0, dv_quo[DivSteps][l]});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      out_vld_q <= dv_vld[DivSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_ang_q       <= dv_ang[DivSteps];
      out_side_q.zero <= (dv_n[DivSteps] == '0);
      out_side_q.neg  <= dv_neg[DivSteps];
      out_side_q.ux   <= u_w[0];
      out_side_q.uy   <= u_w[1];
      out_side_q.uz   <= u_w[2];
    end
  end

  assign valid_o = out_vld_q;
  assign angle_o = out_ang_q;
  assign side_o  = out_side_q;

endmodule

[hw/rtl/rodr_cordic.sv]
// ----------------------------------------------------------------------------
// Pipelined rotation-mode CORDIC
// One micro-rotation per register stage; returns gain-corrected cosine in X
// and sine in Y for an angle in [-pi/2, pi/2], Q30.
// ----------------------------------------------------------------------------
module rodr_cordic #(
  parameter int unsigned STAGES = 24
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic signed [33:0]   angle_i,
  input  rodr_pkg::rodr_side_t side_i,
  output logic                 valid_o,
  output logic signed [33:0]   x_o,
  output logic signed [33:0]   y_o,
  output rodr_pkg::rodr_side_t side_o
);

  logic                 cv [0:STAGES];
  logic signed [33:0]   cx [0:STAGES];
  logic signed [33:0]   cy [0:STAGES];
  logic signed [33:0]   cz [0:STAGES];
  rodr_pkg::rodr_side_t cs [0:STAGES];

  assign cv[0] = valid_i;
  assign cx[0] = rodr_pkg::CordicGainInv;
  assign cy[0] = '0;
  assign cz[0] = angle_i;
  assign cs[0] = side_i;

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic signed [33:0] dx_w, dy_w, da_w;

    assign dx_w = cy[i] >>> i;
    assign dy_w = cx[i] >>> i;
    assign da_w = rodr_pkg::atan_q30(i);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cv[i+1] <= 1'b0;
      end else if (en_i) begin
        cv[i+1] <= cv[i];
      end
    end

    // Rotate toward zero residual angle; a zero residual counts as positive.
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!cz[i][33]) begin
          cx[i+1] <= cx[i] - dx_w;
          cy[i+1] <= cy[i] + dy_w;
          cz[i+1] <= cz[i] - da_w;
        end else begin
          cx[i+1] <= cx[i] + dx_w;
          cy[i+1] <= cy[i] - dy_w;
          cz[i+1] <= cz[i] + da_w;
        end
        cs[i+1] <= cs[i];
      end
    end
  end

  assign valid_o = cv[STAGES];
  assign x_o     = cx[STAGES];
  assign y_o     = cy[STAGES];
  assign side_o  = cs[STAGES];

endmodule

[hw/rtl/axis_angle_to_rotation_matrix.sv]
// ----------------------------------------------------------------------------
// Rotation vector to 3x3 rotation matrix (Rodrigues' formula)
// Norm by a pipelined square root, axis by a pipelined divider, sine and
// cosine by a pipelined CORDIC, then two rounds of products and a sum.
// ----------------------------------------------------------------------------
// Every stage is a pipeline register.
// Throughput: one transaction per cycle while the output is not stalled.
// The latency is set by the 32-stage square root, the 31-stage divider and
// the CORDIC chain. A stall at the output holds the whole pipeline.
// Reset clears all valid bits; the data registers are not reset.
// ----------------------------------------------------------------------------
module axis_angle_to_rotation_matrix #(
  parameter int CORDIC_STAGES = 24,
  parameter int FRAC_BITS_OUT = 30
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rodr_pkg::rodr_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rodr_pkg::rodr_out_t out_data_o
);

  localparam int ShUp = (FRAC_BITS_OUT >= 30) ? (FRAC_BITS_OUT - 30) : 0;
  localparam int ShDn = (FRAC_BITS_OUT < 30) ? (30 - FRAC_BITS_OUT) : 1;

  // Product of two Q30 values, rounded half up.
  function automatic logic signed [33:0] mul30(input logic signed [33:0] a,
                                               input logic signed [33:0] b);
    logic signed [67:0] p;
    p = (68'(a) * 68'(b)) + (68'sd1 <<< 29);
    return p[63:30];
  endfunction

  // Saturate to +-1.0 and scale to the output format.
  function automatic logic [31:0] to_out(input logic signed [34:0] v);
    logic signed [34:0] s;
    logic signed [63:0] w;
    s = v;
    if (v > 35'sd1073741824) begin
      s = 35'sd1073741824;
    end else if (v < -35'sd1073741824) begin
      s = -35'sd1073741824;
    end
    if (FRAC_BITS_OUT >= 30) begin
      w = 64'(s) <<< ShUp;
    end else begin
      w = (64'(s) + (64'sd1 <<< (ShDn - 1))) >>> ShDn;
    end
    return w[31:0];
  endfunction

  logic en;
  logic out_valid_q;

  // The whole pipeline advances whenever the output register can move.
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // Norm, axis and reduced angle.
  logic                 nm_vld;
  logic signed [33:0]   nm_ang;
  rodr_pkg::rodr_side_t nm_side;

  rodr_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .valid_o (nm_vld),
    .angle_o (nm_ang),
    .side_o  (nm_side)
  );

  // Sine and cosine.
  logic                 cd_vld;
  logic signed [33:0]   cd_x, cd_y;
  rodr_pkg::rodr_side_t cd_side;

  rodr_cordic #(
    .STAGES (CORDIC_STAGES)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (nm_vld),
    .angle_i (nm_ang),
    .side_i  (nm_side),
    .valid_o (cd_vld),
    .x_o     (cd_x),
    .y_o     (cd_y),
    .side_o  (cd_side)
  );

  // First products: t times axis, axis times sine.
  logic               p1_vld_q, p1_zero_q;
  logic signed [33:0] p1_c_q, p1_tx_q, p1_ty_q, p1_tz_q, p1_xs_q, p1_ys_q, p1_zs_q;
  logic signed [33:0] p1_ux_q, p1_uy_q, p1_uz_q;
  logic signed [33:0] c_w, t_w, ux_w, uy_w, uz_w;

  assign c_w  = cd_side.neg ? -cd_x : cd_x;
  assign t_w  = rodr_pkg::OneQ30 - c_w;
  assign ux_w = 34'(cd_side.ux);
  assign uy_w = 34'(cd_side.uy);
  assign uz_w = 34'(cd_side.uz);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q <= 1'b0;
    end else if (en) begin
      p1_vld_q <= cd_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_zero_q <= cd_side.zero;
      p1_c_q    <= c_w;
      p1_tx_q   <= mul30(t_w, ux_w);
      p1_ty_q   <= mul30(t_w, uy_w);
      p1_tz_q   <= mul30(t_w, uz_w);
      p1_xs_q   <= mul30(ux_w, cd_y);
      p1_ys_q   <= mul30(uy_w, cd_y);
      p1_zs_q   <= mul30(uz_w, cd_y);
      p1_ux_q   <= ux_w;
      p1_uy_q   <= uy_w;
      p1_uz_q   <= uz_w;
    end
  end

  // Second products: the symmetric outer-product terms.
  logic               p2_vld_q, p2_zero_q;
  logic signed [33:0] p2_c_q, p2_xs_q, p2_ys_q, p2_zs_q;
  logic signed [33:0] p2_xx_q, p2_xy_q, p2_xz_q, p2_yy_q, p2_yz_q, p2_zz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_vld_q <= 1'b0;
    end else if (en) begin
      p2_vld_q <= p1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p2_zero_q <= p1_zero_q;
      p2_c_q    <= p1_c_q;
      p2_xs_q   <= p1_xs_q;
      p2_ys_q   <= p1_ys_q;
      p2_zs_q   <= p1_zs_q;
      p2_xx_q   <= mul30(p1_tx_q, p1_ux_q);
      p2_xy_q   <= mul30(p1_tx_q, p1_uy_q);
      p2_xz_q   <= mul30(p1_tx_q, p1_uz_q);
      p2_yy_q   <= mul30(p1_ty_q, p1_uy_q);
      p2_yz_q   <= mul30(p1_ty_q, p1_uz_q);
      p2_zz_q   <= mul30(p1_tz_q, p1_uz_q);
    end
  end

  // Matrix sums; a zero-length vector gives the identity.
  logic signed [34:0] m_w [0:8];
  rodr_pkg::rodr_out_t out_d, out_data_q;

  always_comb begin
    m_w[0] = 35'(p2_xx_q) + 35'(p2_c_q);
    m_w[1] = 35'(p2_xy_q) - 35'(p2_zs_q);
    m_w[2] = 35'(p2_xz_q) + 35'(p2_ys_q);
    m_w[3] = 35'(p2_xy_q) + 35'(p2_zs_q);
    m_w[4] = 35'(p2_yy_q) + 35'(p2_c_q);
    m_w[5] = 35'(p2_yz_q) - 35'(p2_xs_q);
    m_w[6] = 35'(p2_xz_q) - 35'(p2_ys_q);
    m_w[7] = 35'(p2_yz_q) + 35'(p2_xs_q);
    m_w[8] = 35'(p2_zz_q) + 35'(p2_c_q);
    if (p2_zero_q) begin
      for (int k = 0; k < 9; k++) begin
        m_w[k] = ((k % 4) == 0) ? 35'sd1073741824 : 35'sd0;
      end
    end
    out_d.m00 = to_out(m_w[0]);
    out_d.m01 = to_out(m_w[1]);
    out_d.m02 = to_out(m_w[2]);
    out_d.m10 = to_out(m_w[3]);
    out_d.m11 = to_out(m_w[4]);
    out_d.m12 = to_out(m_w[5]);
    out_d.m20 = to_out(m_w[6]);
    out_d.m21 = to_out(m_w[7]);
    out_d.m22 = to_out(m_w[8]);
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= p2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// Testbench for axis_angle_to_rotation_matrix
// A queue of rotation vectors feeds a clocked driver with random gaps. A
// clocked monitor stalls the output at random and compares every matrix,
// field by field, with the matrix that a bit-exact predictor computed when
// the vector was accepted.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CordicStages = 24;
  localparam int FracBitsOut  = 30;
  localparam int IdleLimit    = 3000;
  localparam int RandomItems  = 1350;

  localparam longint OneQ30L    = 64'sd1073741824;
  localparam longint TwoPiQ28L  = 64'sd1686629713;
  localparam longint PiQ30L     = 64'sd3373259426;
  localparam longint HalfPiQ30L = 64'sd1686629713;
  localparam longint GainInvL   = 64'sd652032874;

  // Angles in Q3.28 for the directed vectors.
  localparam int PiQ28     = 843314857;
  localparam int HalfPiQ28 = 421657428;
  localparam int TwoPiQ28  = 1686629713;

  typedef struct {
    rodr_pkg::rodr_in_t vec;
    bit                 drain;  // hold off until every pending matrix has come back
  } vec_item_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  rodr_pkg::rodr_in_t  in_data_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  rodr_pkg::rodr_out_t out_data_o;

  vec_item_t           vec_queue[$];
  rodr_pkg::rodr_out_t matrix_queue[$];
  int                  mismatches = 0;
  int                  send_gap = 0;
  int                  stall_cnt = 0;
  int                  idle_cycles = 0;
  bit                  burst_mode = 1'b0;

  axis_angle_to_rotation_matrix #(
    .CORDIC_STAGES(CordicStages),
    .FRAC_BITS_OUT(FracBitsOut)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #1 clk_i = ~clk_i;

  // Integer square root, bit by bit from the top.
  function automatic longint unsigned isqrt(input longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Q30 product with round half up.
  function automatic longint qmul(input longint a, input longint b);
    return (a * b + (64'sd1 << 29)) >>> 30;
  endfunction

  function automatic longint axis_comp(input longint comp, input longint unsigned n);
    longint unsigned mag;
    longint q;
    mag = (comp < 0) ? -comp : comp;
    q = longint'((mag << 30) / n);
    return (comp < 0) ? -q : q;
  endfunction

  function automatic longint atan_step(input int i);
    longint v;
    case (i)
      0: v = 843314856;
      1: v = 497837829;
      2: v = 263043836;
      3: v = 133525158;
      4: v = 67021686;
      5: v = 33543515;
      6: v = 16775850;
      7: v = 8388437;
      8: v = 4194282;
      9: v = 2097149;
      10: v = 1048575;
      default: v = (i <= 30) ? (64'sd1 <<< (30 - i)) : 0;
    endcase
    return v;
  endfunction

  // Saturate to +-1.0 and scale to the output format.
  function automatic logic [31:0] out_format(input longint v);
    longint w;
    w = v;
    if (w > OneQ30L) w = OneQ30L;
    if (w < -OneQ30L) w = -OneQ30L;
    if (FracBitsOut >= 30) begin
      w = w <<< (FracBitsOut - 30);
    end else begin
      w = (w + (64'sd1 <<< (29 - FracBitsOut))) >>> (30 - FracBitsOut);
    end
    return w[31:0];
  endfunction

  // Rodrigues' formula on the block's fixed-point grid.
  function automatic rodr_pkg::rodr_out_t rotation_matrix(input rodr_pkg::rodr_in_t v);
    longint              vx, vy, vz, x, y, z, c, s, t, tx, ty, tz, xs, ys, zs;
    longint              a, cx, cy, cz, dx, dy;
    longint              m[9];
    longint unsigned     sum, n;
    bit                  neg;
    rodr_pkg::rodr_out_t res;
    vx = v.rot_x;
    vy = v.rot_y;
    vz = v.rot_z;
    sum = longint'(vx * vx) + longint'(vy * vy) + longint'(vz * vz);
    n = isqrt(sum);
    if (n == 0) begin
      for (int k = 0; k < 9; k++) m[k] = (k % 4 == 0) ? OneQ30L : 0;
    end else begin
      x = axis_comp(vx, n);
      y = axis_comp(vy, n);
      z = axis_comp(vz, n);
      // Reduce modulo 2*pi, fold into [-pi/2, pi/2], then rotate.
      a = longint'(n % TwoPiQ28L) * 4;
      neg = 1'b0;
      if (a > PiQ30L) a = a - 2 * PiQ30L;
      if (a > HalfPiQ30L) begin
        a = PiQ30L - a;
        neg = 1'b1;
      end else if (a < -HalfPiQ30L) begin
        a = -PiQ30L - a;
        neg = 1'b1;
      end
      cx = GainInvL;
      cy = 0;
      cz = a;
      for (int i = 0; i < CordicStages; i++) begin
        dx = cy >>> i;
        dy = cx >>> i;
        if (cz >= 0) begin
          cx = cx - dx;
          cy = cy + dy;
          cz = cz - atan_step(i);
        end else begin
          cx = cx + dx;
          cy = cy - dy;
          cz = cz + atan_step(i);
        end
      end
      c = neg ? -cx : cx;
      s = cy;
      t = OneQ30L - c;
      tx = qmul(t, x);
      ty = qmul(t, y);
      tz = qmul(t, z);
      xs = qmul(x, s);
      ys = qmul(y, s);
      zs = qmul(z, s);
      m[0] = qmul(tx, x) + c;
      m[1] = qmul(tx, y) - zs;
      m[2] = qmul(tx, z) + ys;
      m[3] = qmul(tx, y) + zs;
      m[4] = qmul(ty, y) + c;
      m[5] = qmul(ty, z) - xs;
      m[6] = qmul(tx, z) - ys;
      m[7] = qmul(ty, z) + xs;
      m[8] = qmul(tz, z) + c;
    end
    for (int k = 0; k < 9; k++) res[(8 - k) * 32 +: 32] = out_format(m[k]);
    return res;
  endfunction

  function automatic void add_vec(input int x, input int y, input int z,
                                  input bit drain = 1'b0);
    vec_item_t it;
    it.vec.rot_x = x;
    it.vec.rot_y = y;
    it.vec.rot_z = z;
    it.drain = drain;
    vec_queue.push_back(it);
  endfunction

  function automatic int rand_comp();
    int v;
    int sel;
    v = $urandom;
    sel = $urandom_range(0, 9);
    if (sel < 3) return v;                             // full range
    if (sel < 8) return v >>> $urandom_range(1, 31);   // spread of magnitudes
    if (sel < 9) return 0;                             // axis-aligned vectors
    return $urandom_range(0, 6) - 3;                   // tiny components
  endfunction

  // Driver: one transaction from the queue at a time, with random gaps.
  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      matrix_queue.push_back(rotation_matrix(in_data_i));
    end
    if (rst_ni && (!in_valid_i || in_ready_o)) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid_i <= 1'b0;
      end else if (vec_queue.size() != 0 &&
                   !(vec_queue[0].drain && matrix_queue.size() != 0)) begin
        in_valid_i <= 1'b1;
        in_data_i <= vec_queue[0].vec;
        vec_queue.pop_front();
        if ($urandom_range(0, 49) == 0) burst_mode = ~burst_mode;
        send_gap <= burst_mode ? 0 : $urandom_range(0, 5);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor: random output stalls and the matrix comparison.
  always @(posedge clk_i) begin
    rodr_pkg::rodr_out_t want;
    string               names[9];
    names = '{"m00", "m01", "m02", "m10", "m11", "m12", "m20", "m21", "m22"};
    if (out_valid_o && out_ready_i) begin
      if (matrix_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected matrix %h", out_data_o);
      end else begin
        want = matrix_queue.pop_front();
        for (int k = 0; k < 9; k++) begin
          if (out_data_o[(8 - k) * 32 +: 32] !== want[(8 - k) * 32 +: 32]) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%s mismatch: expected %0d, got %0d", names[k],
                       $signed(want[(8 - k) * 32 +: 32]),
                       $signed(out_data_o[(8 - k) * 32 +: 32]));
            end
          end
        end
      end
    end
    if (rst_ni) begin
      if (stall_cnt > 0) begin
        stall_cnt <= stall_cnt - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (out_valid_o) stall_cnt <= burst_mode ? 0 : $urandom_range(0, 5);
      end
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (rst_ni) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("axis_angle_to_rotation_matrix verification failed");
        $finish;
      end
    end
  end

  initial begin
    // Directed: zero vector, extremes, single LSBs, folds near pi/2, pi, 2*pi.
    add_vec(0, 0, 0);
    add_vec(32'h7fffffff, 0, 0);
    add_vec(0, 32'h80000000, 0);
    add_vec(0, 0, 32'h7fffffff);
    add_vec(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    add_vec(32'h80000000, 32'h80000000, 32'h80000000);
    add_vec(32'h80000000, 32'h7fffffff, 32'h80000000);
    add_vec(1, 0, 0);
    add_vec(0, -1, 0);
    add_vec(1, 1, -1);
    add_vec(HalfPiQ28, 0, 0);
    add_vec(0, HalfPiQ28 + 1, 0);
    add_vec(0, 0, PiQ28);
    add_vec(-PiQ28 - 1, 0, 0);
    add_vec(0, PiQ28 - 1, 0);
    add_vec(0, 0, TwoPiQ28);
    add_vec(TwoPiQ28 - 1, 0, 0);
    add_vec(0, -TwoPiQ28 - 1, 0);
    add_vec(PiQ28 + HalfPiQ28, 0, 0);
    add_vec(HalfPiQ28, HalfPiQ28, HalfPiQ28);
    add_vec(-HalfPiQ28, PiQ28, -TwoPiQ28);
    add_vec(0, 0, 0, 1'b1);
    for (int i = 0; i < RandomItems; i++) begin
      add_vec(rand_comp(), rand_comp(), rand_comp(), $urandom_range(0, 299) == 0);
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (vec_queue.size() == 0 && !in_valid_i && matrix_queue.size() == 0);
    repeat (150) @(posedge clk_i);
    if (mismatches == 0 && matrix_queue.size() == 0) begin
      $display("axis_angle_to_rotation_matrix verification clean");
    end else begin
      $display("axis_angle_to_rotation_matrix verification failed");
    end
    $finish;
  end

endmodule
